>>> sv/hir_pkg.sv
// Shared types and constants for the handshake instruction ROM.
// Holds beat payload structs, phase and status codes and store geometry.
// No dependencies; hir_store, hir_ctrl, the top level and the testbench import it.
package hir_pkg;

	// Store geometry: byte addressed, four byte lanes per row
	localparam int STORE_BYTES = 65536;
	localparam int ADDR_BITS   = $clog2(STORE_BYTES);
	localparam int LANES       = 4;
	localparam int ROWS        = STORE_BYTES / LANES;
	localparam int ROW_BITS    = $clog2(ROWS);
	localparam int COUNT_BITS  = 8;
	localparam int LEN_BITS    = 17;
	localparam int CFG_BITS    = 17;

	// Item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	// Answer status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FAULT    = 2'd1;
	localparam logic [1:0] ST_END      = 2'd2;
	localparam logic [1:0] ST_RESERVED = 2'h3;

	// Configuration register indexes
	localparam logic [1:0] CFG_REQUEST_WAIT     = 2'd0;
	localparam logic [1:0] CFG_RESPONSE_LATENCY = 2'd1;
	localparam logic [1:0] CFG_PROGRAM_LENGTH   = 2'd2;

	typedef enum logic [1:0] {
		PH_ACCEPT = 2'd0,
		PH_WAIT   = 2'd1,
		PH_HOLD   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 sync_reset;
		logic                 fetch_valid;
		logic [31:0]          fetch_address;
		logic                 consumer_ready;
		logic [ADDR_BITS-1:0] load_address;
		logic [7:0]           load_byte;
	} item_t;

	typedef struct packed {
		logic        fetch_ready;
		logic        answer_valid;
		logic [31:0] answer_word;
		logic [1:0]  answer_status;
	} result_t;

	typedef struct packed {
		logic [1:0]          index;
		logic [CFG_BITS-1:0] data;
	} cfg_t;

	// Outcome of one tick, from the protocol controller to the result stages
	typedef struct packed {
		logic       idle;
		logic       answer;
		logic       ok;
		logic       fetch_ready;
		logic       answer_valid;
		logic [1:0] answer_status;
	} step_t;

endpackage

>>> sv/hir_stream_if.sv
// Valid/ready channel used for item, result and configuration beats.
// Payload type is set per instance; depends on nothing else.
interface hir_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/hir_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module hir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/hir_store.sv
// Program store: four byte lanes of hir_ram plus the clearing sweep.
// Depends on hir_pkg and hir_ram.
module hir_store import hir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [7:0]           wr_byte,
	input  logic                 clear_start,
	input  logic                 rd_en,
	input  logic [ROW_BITS-1:0]  rd_row,
	output logic [8*LANES-1:0]   rd_word,
	output logic                 busy
);

	logic                busy_q;
	logic [ROW_BITS-1:0] row_q;

	// Sweep every row to zero after reset and on a clear beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (clear_start) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (busy_q) begin
			row_q <= row_q + ROW_BITS'(1);
			if (row_q == ROW_BITS'(ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	// One RAM per byte lane; the sweep writes all lanes at once
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic                lane_we;
		logic [ROW_BITS-1:0] lane_waddr;
		logic [7:0]          lane_wdata;

		assign lane_we    = busy_q
			|| (wr_en && wr_addr[1:0] == 2'(g));
		assign lane_waddr = busy_q ? row_q : wr_addr[ADDR_BITS-1:2];
		assign lane_wdata = busy_q ? 8'h00 : wr_byte;

		hir_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_lane (
			.clk  (clk),
			.we   (lane_we),
			.waddr(lane_waddr),
			.wdata(lane_wdata),
			.re   (rd_en),
			.raddr(rd_row),
			.rdata(rd_word[8*g +: 8])
		);
	end

`ifndef SYNTHESIS
	a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr_en)
		else $error("byte write during clearing sweep");
`endif

endmodule

>>> sv/hir_ctrl.sv
// Fetch protocol controller: configuration registers, ready/wait counter,
// response latency counter and answer status. Depends on hir_pkg.
module hir_ctrl import hir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cfg_t                cfg_beat,
	input  logic                tick_en,
	input  item_t               tick,
	output step_t               step,
	output logic [ROW_BITS-1:0] rd_row
);

	logic [COUNT_BITS-1:0] request_wait_q;
	logic [COUNT_BITS-1:0] response_latency_q;
	logic [LEN_BITS-1:0]   program_length_q;

	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] wait_count_q, wait_count_d;
	logic [COUNT_BITS-1:0] latency_left_q, latency_left_d;
	logic [31:0]           held_address_q, held_address_d;
	logic                  ready_q, ready_d;
	logic                  valid_q, valid_d;
	logic [1:0]            status_q, status_d;

	logic                  answer;
	logic                  aligned;
	logic                  end_hit;
	logic                  ok_hit;
	logic [32:0]           addr_ext;
	logic [32:0]           addr_plus4;
	logic [32:0]           len_ext;
	logic [COUNT_BITS-1:0] wait_inc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_wait_q     <= '0;
			response_latency_q <= COUNT_BITS'(1);
			program_length_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_beat.index)
				CFG_REQUEST_WAIT:     request_wait_q     <= cfg_beat.data[COUNT_BITS-1:0];
				CFG_RESPONSE_LATENCY: response_latency_q <= cfg_beat.data[COUNT_BITS-1:0];
				CFG_PROGRAM_LENGTH:   program_length_q   <= cfg_beat.data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Status of the held address against the program bounds
	assign addr_ext   = {1'b0, held_address_q};
	assign addr_plus4 = addr_ext + 33'd4;
	assign len_ext    = 33'(program_length_q);
	assign aligned    = held_address_q[1:0] == 2'b00;
	assign end_hit    = aligned && addr_ext == len_ext;
	assign ok_hit     = aligned && addr_plus4 <= len_ext
		&& addr_plus4 <= 33'(STORE_BYTES);
	assign wait_inc   = wait_count_q + COUNT_BITS'(1);

	assign rd_row = held_address_q[ADDR_BITS-1:2];

	// Next protocol state for one tick
	always_comb begin
		phase_d        = phase_q;
		wait_count_d   = wait_count_q;
		latency_left_d = latency_left_q;
		held_address_d = held_address_q;
		ready_d        = ready_q;
		valid_d        = valid_q;
		status_d       = status_q;
		answer         = 1'b0;
		if (tick.sync_reset) begin
			phase_d        = PH_ACCEPT;
			wait_count_d   = '0;
			latency_left_d = '0;
			held_address_d = '0;
			ready_d        = request_wait_q == '0;
			valid_d        = 1'b0;
			status_d       = ST_RESERVED;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					ready_d = 1'b0;
					if (latency_left_q > COUNT_BITS'(1)) begin
						latency_left_d = latency_left_q - COUNT_BITS'(1);
					end else begin
						latency_left_d = '0;
						answer         = 1'b1;
						status_d       = end_hit ? ST_END : (ok_hit ? ST_OK : ST_FAULT);
						valid_d        = 1'b1;
						phase_d        = PH_HOLD;
					end
				end
				PH_HOLD: begin
					ready_d = 1'b0;
					if (valid_q && tick.consumer_ready) begin
						valid_d      = 1'b0;
						phase_d      = PH_ACCEPT;
						wait_count_d = '0;
						ready_d      = request_wait_q == '0;
					end
				end
				default: begin
					phase_d = PH_ACCEPT;
					valid_d = 1'b0;
					if (request_wait_q == '0) begin
						ready_d = 1'b1;
					end else if (!tick.fetch_valid) begin
						wait_count_d = '0;
						ready_d      = 1'b0;
					end else if (wait_count_q < request_wait_q) begin
						wait_count_d = wait_inc;
						ready_d      = wait_inc == request_wait_q;
					end
					// Take the request when ready was already high
					if (tick.fetch_valid && ready_q) begin
						held_address_d = tick.fetch_address;
						ready_d        = 1'b0;
						latency_left_d = response_latency_q;
						phase_d        = PH_WAIT;
					end
				end
			endcase
		end
		step.idle          = tick.sync_reset;
		step.answer        = answer;
		step.ok            = answer && status_d == ST_OK;
		step.fetch_ready   = ready_d;
		step.answer_valid  = valid_d;
		step.answer_status = status_d;
	end

	// Protocol state advances on tick beats only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ACCEPT;
			wait_count_q   <= '0;
			latency_left_q <= '0;
			held_address_q <= '0;
			ready_q        <= 1'b1;
			valid_q        <= 1'b0;
			status_q       <= ST_RESERVED;
		end else if (tick_en) begin
			phase_q        <= phase_d;
			wait_count_q   <= wait_count_d;
			latency_left_q <= latency_left_d;
			held_address_q <= held_address_d;
			ready_q        <= ready_d;
			valid_q        <= valid_d;
			status_q       <= status_d;
		end
	end

`ifndef SYNTHESIS
	a_wait_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> !ready_q)
		else $error("ready high while a request is in flight");
	a_valid_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> phase_q == PH_HOLD)
		else $error("answer presented outside hold phase");
	a_answer_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && answer |=> valid_q && phase_q == PH_HOLD)
		else $error("answer did not raise answer_valid");
`endif

endmodule

>>> sv/handshake_instruction_rom.sv
// Handshake instruction ROM: a tick beat passes the input register, second
// stage and result register; one item is taken per cycle while the result
// side drains, the store is idle and no clear beat is in the input register.
// Load and clear beats give no result. After reset and each clear beat a sweep
// zeroes the store one row per cycle (no item taken); cfg is always ready.
// Reset: request_wait 0, response_latency 1, program_length 0, ready high.
module handshake_instruction_rom import hir_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	hir_stream_if.sink   item,
	hir_stream_if.source result,
	hir_stream_if.sink   cfg
);

	logic                advance;
	logic                store_busy;
	logic                clear_in_s1;
	logic                accept;
	logic                valid_s1;
	item_t               item_s1;
	logic                tick_en;
	logic                load_en;
	logic                clear_en;
	step_t               step;
	logic [ROW_BITS-1:0] rd_row;
	logic [31:0]         rd_word;
	logic                valid_s2;
	step_t               step_s2;
	logic                res_valid_q;
	logic                res_ready_q;
	logic                res_avalid_q;
	logic [1:0]          res_status_q;
	logic [31:0]         word_q;

	// The whole pipe moves when the result register is free or being taken
	assign advance     = !res_valid_q || result.ready;
	assign clear_in_s1 = valid_s1 && item_s1.kind == KIND_CLEAR;
	assign item.ready  = advance && !store_busy && !clear_in_s1;
	assign accept      = item.valid && item.ready;
	assign cfg.ready   = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.payload;
		end
	end

	assign tick_en  = advance && valid_s1 && item_s1.kind == KIND_TICK;
	assign load_en  = advance && valid_s1 && item_s1.kind == KIND_LOAD;
	assign clear_en = advance && valid_s1 && item_s1.kind == KIND_CLEAR;

	hir_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg.valid && cfg.ready),
		.cfg_beat(cfg.payload),
		.tick_en (tick_en),
		.tick    (item_s1),
		.step    (step),
		.rd_row  (rd_row)
	);

	hir_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (load_en),
		.wr_addr    (item_s1.load_address),
		.wr_byte    (item_s1.load_byte),
		.clear_start(clear_en),
		.rd_en      (advance),
		.rd_row     (rd_row),
		.rd_word    (rd_word),
		.busy       (store_busy)
	);

	// Second stage: tick outcome, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= tick_en;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_s2 <= step;
		end
	end

	// Result register; the word is held state between answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			word_q      <= '0;
		end else if (advance) begin
			res_valid_q <= valid_s2;
			if (valid_s2) begin
				if (step_s2.idle) begin
					word_q <= '0;
				end else if (step_s2.answer) begin
					word_q <= step_s2.ok ? rd_word : 32'h0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			res_ready_q  <= step_s2.fetch_ready;
			res_avalid_q <= step_s2.answer_valid;
			res_status_q <= step_s2.answer_status;
		end
	end

	assign result.valid                 = res_valid_q;
	assign result.payload.fetch_ready   = res_ready_q;
	assign result.payload.answer_valid  = res_avalid_q;
	assign result.payload.answer_word   = word_q;
	assign result.payload.answer_status = res_status_q;

`ifndef SYNTHESIS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |-> !store_busy)
		else $error("item accepted during clearing sweep");
	a_word_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.answer_status != ST_OK
		|-> result.payload.answer_word == 32'h0)
		else $error("non-zero word with a status other than ok");
`endif

endmodule

>>> test/tb_handshake_instruction_rom.sv
// Testbench for handshake_instruction_rom: streams tick, load and clear beats,
// writes the three registers between phases and checks every result beat.
// Depends on hir_pkg, hir_stream_if and handshake_instruction_rom from the RTL.
module tb_handshake_instruction_rom;
	import hir_pkg::*;

	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         LONG_HOLD   = 300;
	localparam int         SETTLE      = 8;
	localparam int         PHASES      = 6;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	hir_stream_if #(.payload_t(item_t))   item_ch ();
	hir_stream_if #(.payload_t(result_t)) result_ch ();
	hir_stream_if #(.payload_t(cfg_t))    cfg_ch ();

	handshake_instruction_rom dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the ROM contents, registers and fetch protocol
	logic [7:0]  rom_image [STORE_BYTES];
	logic [7:0]  set_wait;
	logic [7:0]  set_latency;
	logic [16:0] set_length;
	phase_t      m_phase;
	logic [7:0]  m_waited;
	logic [7:0]  m_lat_left;
	logic [31:0] m_addr;
	logic        m_ready;
	logic        m_valid;
	logic [31:0] m_word;
	logic [1:0]  m_status;

	item_t       pending_beats [$];
	result_t     expected_beats [$];
	result_t     want;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;

	int unsigned send_gap;
	bit          send_steady;
	int unsigned take_gap;
	bit          take_steady;
	int unsigned hold_left;
	bit          hold_done;
	bit          hold_request;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag(input string what);
		errors++;
		if (errors <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			flag($sformatf("%s is %0h, expected %0h", name, got, exp_val));
	endtask

	function automatic void idle_protocol();
		m_phase    = PH_ACCEPT;
		m_waited   = '0;
		m_lat_left = '0;
		m_addr     = '0;
		m_ready    = (set_wait == 8'd0);
		m_valid    = 1'b0;
		m_word     = '0;
		m_status   = ST_RESERVED;
	endfunction

	function automatic void wipe_image();
		foreach (rom_image[i])
			rom_image[i] = 8'h00;
	endfunction

	// Advance the mirror by one accepted beat; a tick beat leaves one expectation
	function automatic void step_rom(input item_t it);
		logic        old_ready;
		logic        old_valid;
		logic [32:0] word_end;
		int unsigned base;
		result_t     r;
		old_ready = m_ready;
		old_valid = m_valid;
		if (it.kind == KIND_CLEAR) begin
			wipe_image();
		end else if (it.kind == KIND_LOAD) begin
			rom_image[it.load_address] = it.load_byte;
		end else if (it.kind == KIND_TICK) begin
			if (it.sync_reset) begin
				idle_protocol();
			end else if (m_phase == PH_WAIT) begin
				m_ready = 1'b0;
				if (m_lat_left > 8'd1) begin
					m_lat_left = m_lat_left - 8'd1;
				end else begin
					// latency spent: look the word up and hold the answer
					m_lat_left = '0;
					word_end   = {1'b0, m_addr} + 33'd4;
					m_word     = '0;
					m_status   = ST_FAULT;
					if (m_addr[1:0] == 2'b00 && m_addr == 32'(set_length)) begin
						m_status = ST_END;
					end else if (m_addr[1:0] == 2'b00 && word_end <= 33'(set_length)
							&& word_end <= 33'(STORE_BYTES)) begin
						base     = 32'(m_addr[ADDR_BITS-1:0]);
						m_word   = {rom_image[base + 3], rom_image[base + 2],
							rom_image[base + 1], rom_image[base]};
						m_status = ST_OK;
					end
					m_valid = 1'b1;
					m_phase = PH_HOLD;
				end
			end else if (m_phase == PH_HOLD) begin
				m_ready = 1'b0;
				if (old_valid && it.consumer_ready) begin
					m_valid  = 1'b0;
					m_phase  = PH_ACCEPT;
					m_waited = '0;
					m_ready  = (set_wait == 8'd0);
				end
			end else begin
				m_phase = PH_ACCEPT;
				m_valid = 1'b0;
				// ready rises after the configured run of valid cycles
				if (set_wait == 8'd0) begin
					m_ready = 1'b1;
				end else if (!it.fetch_valid) begin
					m_waited = '0;
					m_ready  = 1'b0;
				end else if (m_waited < set_wait) begin
					m_waited = m_waited + 8'd1;
					m_ready  = (m_waited == set_wait);
				end
				if (it.fetch_valid && old_ready) begin
					m_addr     = it.fetch_address;
					m_ready    = 1'b0;
					m_lat_left = set_latency;
					m_phase    = PH_WAIT;
				end
			end
			r.fetch_ready   = m_ready;
			r.answer_valid  = m_valid;
			r.answer_word   = m_word;
			r.answer_status = m_status;
			expected_beats.push_back(r);
		end
	endfunction

	function automatic item_t rand_beat(input logic [1:0] kind);
		item_t b;
		b.kind           = kind;
		b.sync_reset     = 1'($urandom_range(0, 1));
		b.fetch_valid    = 1'($urandom_range(0, 1));
		b.fetch_address  = $urandom;
		b.consumer_ready = 1'($urandom_range(0, 1));
		b.load_address   = ADDR_BITS'($urandom);
		b.load_byte      = 8'($urandom);
		return b;
	endfunction

	function automatic void push_tick(input logic fv, input logic [31:0] a, input logic cr,
			input logic sr);
		item_t b;
		b                = rand_beat(KIND_TICK);
		b.fetch_valid    = fv;
		b.fetch_address  = a;
		b.consumer_ready = cr;
		b.sync_reset     = sr;
		pending_beats.push_back(b);
	endfunction

	function automatic void push_load(input logic [15:0] a, input logic [7:0] v);
		item_t b;
		b              = rand_beat(KIND_LOAD);
		b.load_address = a;
		b.load_byte    = v;
		pending_beats.push_back(b);
	endfunction

	// Fetch addresses cluster around the loaded bytes and the program end
	function automatic logic [31:0] pick_fetch_addr(input int unsigned len_v);
		int unsigned top;
		top = len_v & ~32'd3;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return 4 * $urandom_range(0, 64);
		4, 5, 6: return (top >= 8) ? top - 8 + 4 * $urandom_range(0, 4)
			: 4 * $urandom_range(0, 4);
		7: return len_v;
		8: return 4 * $urandom_range(0, 64) + $urandom_range(1, 3);
		default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: value[CFG_BITS-1:0]};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
		CFG_REQUEST_WAIT: set_wait = value[7:0];
		CFG_RESPONSE_LATENCY: set_latency = value[7:0];
		default: set_length = value[16:0];
		endcase
	endtask

	// Hold off until every beat is sent and answered, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || item_ch.valid || expected_beats.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic plan_phase(input int unsigned wait_v, input int unsigned lat_v,
			input int unsigned len_v, input int unsigned count, input bit with_clear);
		int unsigned made;
		int unsigned k;
		int unsigned sel;
		logic [31:0] a;
		write_reg(CFG_REQUEST_WAIT, wait_v);
		write_reg(CFG_RESPONSE_LATENCY, lat_v);
		write_reg(CFG_PROGRAM_LENGTH, len_v);
		@(negedge clk);
		made = 0;
		while (made < count) begin
			if (with_clear && made >= count / 2) begin
				pending_beats.push_back(rand_beat(KIND_CLEAR));
				with_clear = 1'b0;
				made++;
			end
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				// well-formed fetch: keep valid on one address, mostly past wait and latency
				a = pick_fetch_addr(len_v);
				if ($urandom_range(0, 9) < 7)
					k = wait_v + $urandom_range(1, lat_v + 6);
				else
					k = $urandom_range(1, wait_v + lat_v + 6);
				repeat (k) push_tick(1'b1, a, $urandom_range(0, 9) < 7, 1'b0);
				made += k;
			end else if (sel < 78) begin
				k = $urandom_range(1, 4);
				repeat (k) push_tick(1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1)), 1'b0);
				made += k;
			end else if (sel < 94) begin
				k = $urandom_range(1, 4);
				repeat (k) begin
					case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: push_load(16'($urandom_range(0, 263)), 8'($urandom));
					5, 6, 7: push_load(16'(len_v - 16 + $urandom_range(0, 19)),
						8'($urandom));
					default: push_load(16'($urandom), 8'($urandom));
					endcase
				end
				made += k;
			end else if (sel < 97) begin
				push_tick(1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1)), 1'b1);
				made++;
			end else begin
				pending_beats.push_back(rand_beat(KIND_SPARE));
			end
		end
	endtask

	// Item driver: one beat offered at a time, random gap after each unless steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			item_ch.payload <= '0;
			send_gap = 0;
			send_steady = 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				step_rom(item_ch.payload);
				send_gap = send_steady ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 49) == 0)
					send_steady = !send_steady;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap == 0 && pending_beats.size() != 0) begin
					item_ch.valid   <= 1'b1;
					item_ch.payload <= pending_beats.pop_front();
				end else begin
					item_ch.valid <= 1'b0;
					if (send_gap > 0)
						send_gap--;
				end
			end
		end
	end

	// Result monitor: check each beat, stall at random and once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_gap = 0;
			take_steady = 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_beats.size() == 0) begin
					flag("result beat with no expectation waiting");
				end else begin
					want = expected_beats.pop_front();
					compare_field("fetch_ready", 32'(result_ch.payload.fetch_ready),
						32'(want.fetch_ready));
					compare_field("answer_valid", 32'(result_ch.payload.answer_valid),
						32'(want.answer_valid));
					compare_field("answer_word", result_ch.payload.answer_word, want.answer_word);
					compare_field("answer_status", 32'(result_ch.payload.answer_status),
						32'(want.answer_status));
				end
				take_gap = take_steady ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 49) == 0)
					take_steady = !take_steady;
			end else if (take_gap > 0) begin
				take_gap--;
			end
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			result_ch.ready <= (take_gap == 0 && hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_handshake_instruction_rom NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned plan_wait [PHASES] = '{0, 2, 1, 255, 0, 0};
		int unsigned plan_lat [PHASES]  = '{1, 3, 0, 1, 255, 1};
		int unsigned plan_len [PHASES]  = '{64, 62, 65536, 32, 0, 0};
		int unsigned plan_n [PHASES]    = '{250, 250, 200, 60, 100, 250};
		bit          plan_clear [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		logic [31:0] probe [5] = '{32'h0, 32'h4, 32'h8, 32'h2, 32'hFFFF_FFFC};
		int unsigned w;
		int unsigned l;
		int unsigned n;
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.payload  = '0;
		hold_request    = 1'b0;
		set_wait        = '0;
		set_latency     = 8'd1;
		set_length      = '0;
		wipe_image();
		idle_protocol();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: byte extremes, spare kind, each status, sync reset, clear
		write_reg(CFG_PROGRAM_LENGTH, 8);
		@(negedge clk);
		push_load(16'd0, 8'h00);
		push_load(16'd1, 8'hFF);
		push_load(16'd2, 8'h5A);
		push_load(16'd3, 8'hA5);
		push_load(16'hFFFF, 8'hFF);
		pending_beats.push_back(rand_beat(KIND_SPARE));
		push_tick(1'b0, 32'h0, 1'b0, 1'b0);
		foreach (probe[i])
			repeat (3) push_tick(1'b1, probe[i], 1'b1, 1'b0);
		push_tick(1'b1, 32'h0, 1'b1, 1'b1);
		pending_beats.push_back(rand_beat(KIND_CLEAR));
		drain();

		// Random phases through the register extremes
		for (int p = 0; p < PHASES; p++) begin
			w = plan_wait[p];
			l = plan_lat[p];
			n = plan_len[p];
			if (p == PHASES - 1) begin
				w = $urandom_range(0, 7);
				l = $urandom_range(1, 8);
				n = $urandom_range(0, 260);
			end
			plan_phase(w, l, n, plan_n[p], plan_clear[p]);
			if (p == 0)
				hold_request = 1'b1;
			drain();
		end

		if (errors == 0)
			$display("tb_handshake_instruction_rom OK");
		else
			$display("tb_handshake_instruction_rom NOT OK");
		$finish;
	end

endmodule
